>>> hw/rtl/ctgr_pkg.sv
`timescale 1ns / 1ps
package ctgr_pkg;

  typedef enum logic [1:0] {
    REG_TEMPERATURE = 2'd0,
    REG_RAMP_LENGTH = 2'd1
  } ctgr_reg_t;

  localparam logic [15:0] T_NORM  = 16'd6500;
  localparam logic [15:0] T_ZERO  = 16'd700;
  localparam logic [15:0] T_SHIFT = 16'd5800;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  localparam logic signed [19:0] KG_LO0 = -20'sd96830;
  localparam logic signed [17:0] KG_LO1 = 18'sd18737;
  localparam logic signed [19:0] KB_LO0 = -20'sd287258;
  localparam logic signed [17:0] KB_LO1 = 18'sd40712;
  localparam logic signed [19:0] KR_HI0 = 20'sd114944;
  localparam logic signed [17:0] KR_HI1 = -18'sd7542;
  localparam logic signed [19:0] KG_HI0 = 20'sd97794;
  localparam logic signed [17:0] KG_HI1 = -18'sd4924;

  localparam logic [16:0] GAIN_ONE = 17'd65536;

  typedef struct packed {
    logic high;
    logic zero;
  } ctgr_branch_t;

  function automatic logic [15:0] ln_tab(input logic [4:0] k);
    logic [15:0] v;
    case (k)
      5'd0:  v = 16'd0;
      5'd1:  v = 16'd3973;
      5'd2:  v = 16'd7719;
      5'd3:  v = 16'd11262;
      5'd4:  v = 16'd14624;
      5'd5:  v = 16'd17822;
      5'd6:  v = 16'd20870;
      5'd7:  v = 16'd23783;
      5'd8:  v = 16'd26573;
      5'd9:  v = 16'd29248;
      5'd10: v = 16'd31818;
      5'd11: v = 16'd34292;
      5'd12: v = 16'd36675;
      5'd13: v = 16'd38975;
      5'd14: v = 16'd41197;
      5'd15: v = 16'd43347;
      default: v = 16'd45426;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/color_temperature_gamma_ramp_core.sv
`timescale 1ns / 1ps
// Gamma ramp generator for a color temperature white point. Set
// temperature_kelvin (index 0) and ramp_length (index 1) while no beat is in
// flight; then each entry_index beat yields one red/green/blue beat, one per
// clock while the output is not stalled. The pipe holds the input register,
// the 2-stage log, the 2-stage gain, the multiply and scale stages and the
// 17-stage restoring divider per channel. Output stall holds the whole pipe.
module color_temperature_gamma_ramp_core #(
  parameter int MAX_RAMP_LENGTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [11:0] entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] red_level,
  output logic [15:0] green_level,
  output logic [15:0] blue_level,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ctgr_pkg::*;

  localparam int SW  = $clog2(MAX_RAMP_LENGTH + 1);
  localparam int PW  = 29;
  localparam int NW  = ((PW + 16 > SW + 15) ? PW + 16 : SW + 15) + 1;
  localparam int MW  = NW - 16;
  localparam int LAT = 24;

  logic [15:0]   temperature_kelvin;
  logic [12:0]   ramp_length;
  logic          en;
  logic [LAT-1:0] vld;

  logic [11:0]   idx0;
  logic [15:0]   t0;
  logic [SW-1:0] s0;
  logic [SW-1:0] s_clamp;

  logic [11:0]   idx_d [4];
  logic [SW-1:0] s_d   [4];

  logic [19:0]   ln;
  ctgr_branch_t  branch;
  logic [16:0]   gain [3];

  logic [PW-1:0] prod [3];
  logic [SW-1:0] s_p;
  logic [MW-1:0] m    [3];
  logic [SW-1:0] s_m;
  logic [15:0]   lvl  [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      temperature_kelvin <= 16'd6500;
      ramp_length        <= 13'd256;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TEMPERATURE: temperature_kelvin <= cfg_data;
        REG_RAMP_LENGTH: ramp_length        <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  assign en       = !(vld[LAT-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end

  always_comb begin
    if (ramp_length == 13'd0) s_clamp = SW'(1);
    else if (32'(ramp_length) > 32'(MAX_RAMP_LENGTH)) s_clamp = SW'(MAX_RAMP_LENGTH);
    else s_clamp = SW'(ramp_length);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx0 <= entry_index;
      t0   <= temperature_kelvin;
      s0   <= s_clamp;
      idx_d[0] <= idx0;
      s_d[0]   <= s0;
      for (int k = 1; k < 4; k++) begin
        idx_d[k] <= idx_d[k-1];
        s_d[k]   <= s_d[k-1];
      end
    end
  end

  ctgr_log u_log (
    .clk    (clk),
    .en     (en),
    .temp   (t0),
    .ln     (ln),
    .branch (branch)
  );

  ctgr_gain u_gain (
    .clk    (clk),
    .en     (en),
    .ln     (ln),
    .branch (branch),
    .gain_r (gain[0]),
    .gain_g (gain[1]),
    .gain_b (gain[2])
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        prod[c] <= PW'(idx_d[3]) * PW'(gain[c]);
        m[c]    <= MW'(((NW'(prod[c]) << 16) - NW'(prod[c]) + (NW'(s_p) << 15)) >> 16);
      end
      s_p <= s_d[3];
      s_m <= s_p;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_div
    ctgr_div #(.MW(MW), .SW(SW)) u_div (
      .clk   (clk),
      .en    (en),
      .num   (m[c]),
      .den   (s_m),
      .level (lvl[c])
    );
  end

  assign red_level   = lvl[0];
  assign green_level = lvl[1];
  assign blue_level  = lvl[2];

endmodule

>>> hw/rtl/ctgr_log.sv
`timescale 1ns / 1ps
module ctgr_log (
  input  logic                  clk,
  input  logic                  en,
  input  logic [15:0]           temp,
  output logic [19:0]           ln,
  output ctgr_pkg::ctgr_branch_t branch
);
  import ctgr_pkg::*;

  logic [15:0]  x;
  logic [3:0]   p_c;
  logic [15:0]  n;
  logic [3:0]   p;
  logic [3:0]   idx;
  logic [10:0]  rem;
  ctgr_branch_t br1;
  ctgr_branch_t br1_next;
  logic [15:0]  lo;
  logic [15:0]  hi;
  logic [26:0]  prod;
  logic [15:0]  frac;

  always_comb begin
    br1_next.high = temp >= T_NORM;
    br1_next.zero = temp <= T_ZERO;
    x = br1_next.high ? temp - T_SHIFT : temp - T_ZERO;
    p_c = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (x[b]) p_c = 4'(b);
    end
    n = 16'(x << (4'd15 - p_c));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p   <= p_c;
      idx <= n[14:11];
      rem <= n[10:0];
      br1 <= br1_next;
    end
  end

  always_comb begin
    lo   = ln_tab({1'b0, idx});
    hi   = ln_tab(5'({1'b0, idx}) + 5'd1);
    prod = 27'(hi - lo) * 27'(rem);
    frac = 16'((prod + 27'd1024) >> 11);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln     <= 20'(p) * 20'(LN2_Q16) + 20'(lo) + 20'(frac);
      branch <= br1;
    end
  end

endmodule

>>> hw/rtl/ctgr_gain.sv
`timescale 1ns / 1ps
module ctgr_gain (
  input  logic                   clk,
  input  logic                   en,
  input  logic [19:0]            ln,
  input  ctgr_pkg::ctgr_branch_t branch,
  output logic [16:0]            gain_r,
  output logic [16:0]            gain_g,
  output logic [16:0]            gain_b
);
  import ctgr_pkg::*;

  logic signed [19:0] k0a, k0b;
  logic signed [17:0] k1a, k1b;
  logic signed [20:0] lns;
  logic signed [39:0] sa, sb;
  ctgr_branch_t       br;
  logic [16:0]        ga, gb;

  function automatic logic [16:0] clamp(input logic signed [39:0] s);
    logic [16:0] g;
    if (s[39] || s == 40'sd0) g = 17'd0;
    else if (|s[38:32]) g = GAIN_ONE;
    else g = 17'((34'(s[31:0]) + 34'd32768) >> 16);
    return g;
  endfunction

  always_comb begin
    lns = signed'({1'b0, ln});
    k0a = branch.high ? KR_HI0 : KG_LO0;
    k1a = branch.high ? KR_HI1 : KG_LO1;
    k0b = branch.high ? KG_HI0 : KB_LO0;
    k1b = branch.high ? KG_HI1 : KB_LO1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa <= 40'(k1a * lns) + (40'(k0a) <<< 16);
      sb <= 40'(k1b * lns) + (40'(k0b) <<< 16);
      br <= branch;
    end
  end

  always_comb begin
    ga = clamp(sa);
    gb = clamp(sb);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (br.high) begin
        gain_r <= ga;
        gain_g <= gb;
        gain_b <= GAIN_ONE;
      end else begin
        gain_r <= GAIN_ONE;
        gain_g <= br.zero ? 17'd0 : ga;
        gain_b <= br.zero ? 17'd0 : gb;
      end
    end
  end

endmodule

>>> hw/rtl/ctgr_div.sv
`timescale 1ns / 1ps
module ctgr_div #(
  parameter int MW = 30,
  parameter int SW = 13
) (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] num,
  input  logic [SW-1:0] den,
  output logic [15:0]   level
);
  localparam int DW = (MW > SW + 16) ? MW : SW + 16;

  logic [DW-1:0] rem [17];
  logic [SW-1:0] dv  [17];
  logic [15:0]   quo [17];
  logic          sat [17];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= DW'(num);
      dv[0]  <= den;
      quo[0] <= 16'd0;
      sat[0] <= DW'(num) >= (DW'(den) << 16);
    end
  end

  for (genvar j = 1; j <= 16; j++) begin : g_stage
    localparam int K = 16 - j;
    logic [DW-1:0] sub;
    logic          take;
    always_comb begin
      sub  = DW'(dv[j-1]) << K;
      take = rem[j-1] >= sub;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= take ? rem[j-1] - sub : rem[j-1];
        dv[j]  <= dv[j-1];
        sat[j] <= sat[j-1];
        quo[j] <= quo[j-1] | (16'(take) << K);
      end
    end
  end

  assign level = sat[16] ? 16'hFFFF : quo[16];

endmodule
